/* src/tmv_pkg.sv */
// Shared types, codes and floating-point helpers for the transposed
// matrix-vector multiply-accumulate block.
// Depends on nothing; every other file uses it by scoped names.
package tmv_pkg;

   // Row storage geometry.
   localparam int MaxRows = 1024;
   localparam int RowW    = $clog2(MaxRows);

   // Input opcodes.
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_MAC  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   // Classified command kinds passed from the front to the back.
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_MAC   = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_RANGE = 2'd3;

   // Result status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_COUNT = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_ALPHA = 2'd0;
   localparam logic [1:0] CSR_BETA  = 2'd1;
   localparam logic [1:0] CSR_ROWS  = 2'd2;
   localparam logic [1:0] CSR_COLS  = 2'd3;

   // Floating-point unit operations.
   localparam logic FPU_MUL = 1'b0;
   localparam logic FPU_ADD = 1'b1;

   // Default NaN produced by an invalid operation.
   localparam logic [31:0] DefaultNan = 32'hFFC0_0000;

   typedef struct packed {
      logic [1:0]      kind;
      logic [RowW-1:0] row;
      logic [31:0]     a_value;
      logic [31:0]     b_value;
      logic [31:0]     c_value;
   } cmd_type;

   typedef struct packed {
      logic [RowW-1:0] out_row;
      logic [31:0]     out_value;
      logic [1:0]      status;
   } rsp_type;

   typedef struct packed {
      logic [31:0] alpha_bits;
      logic [31:0] beta_bits;
      logic [10:0] row_count;
      logic [15:0] col_count;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic        op;
      logic [31:0] x;
      logic [31:0] y;
   } fpu_req_type;

   // True for any NaN encoding.
   function automatic logic is_nan(input logic [31:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
   endfunction

   // True for either infinity.
   function automatic logic is_inf(input logic [31:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
   endfunction

   // True for either zero.
   function automatic logic is_zero(input logic [31:0] v);
      return v[30:0] == 31'd0;
   endfunction

   // Position of the highest set bit of a 48-bit word.
   function automatic logic [5:0] msb48(input logic [47:0] v);
      logic [5:0] pos;
      pos = 6'd0;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) pos = 6'(i);
      end
      return pos;
   endfunction

   // Round to nearest even and pack. The value is x / 2^47 * 2^(e - 127)
   // with the leading one of x at bit 47; small exponents go subnormal.
   function automatic logic [31:0] round_pack(input logic sgn, input logic [47:0] x,
                                              input logic signed [11:0] e,
                                              input logic zero);
      logic [47:0]        xs;
      logic               lost;
      logic [11:0]        sh;
      logic signed [11:0] ee;
      logic [23:0]        m24;
      logic               g;
      logic               st;
      logic [24:0]        m25;
      logic [31:0]        pk;
      logic [31:0]        r;
      xs   = x;
      lost = 1'b0;
      ee   = e;
      if (e < 12'sd1) begin
         sh = 12'(12'sd1 - e);
         if (sh >= 12'd48) begin
            xs   = 48'd0;
            lost = |x;
         end else begin
            xs   = x >> sh;
            lost = |(x & ((48'd1 << sh) - 48'd1));
         end
         ee = 12'sd1;
      end
      m24 = xs[47:24];
      g   = xs[23];
      st  = (|xs[22:0]) | lost;
      m25 = {1'b0, m24} + {24'd0, g & (st | m24[0])};
      pk  = {1'b0, 8'(ee - 12'sd1), 23'd0} + {7'd0, m25};
      if (zero) begin
         r = {sgn, 31'd0};
      end else if (ee >= 12'sd255) begin
         r = {sgn, 8'hFF, 23'd0};
      end else if (pk[30:0] >= 31'h7F80_0000) begin
         r = {sgn, 8'hFF, 23'd0};
      end else begin
         r = {sgn, pk[30:0]};
      end
      return r;
   endfunction

endpackage

/* src/tmv_front.sv */
// Front part: accepts input words, classifies them and queues commands.
// Depends on tmv_pkg.
module tmv_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic [1:0]              opcode,
   input  logic [tmv_pkg::RowW-1:0] row_index,
   input  logic [31:0]             a_value,
   input  logic [31:0]             b_value,
   input  logic [31:0]             c_value,
   input  logic [10:0]             row_count,
   output logic                    cmd_valid,
   output tmv_pkg::cmd_type        cmd,
   input  logic                    cmd_pop
);

   tmv_pkg::cmd_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   tmv_pkg::cmd_type new_cmd;
   logic             keep;
   logic             enq;

   // Classify the incoming word; unused opcodes are dropped.
   always_comb begin
      keep          = 1'b1;
      new_cmd.row     = row_index;
      new_cmd.a_value = a_value;
      new_cmd.b_value = b_value;
      new_cmd.c_value = c_value;
      unique case (opcode)
         tmv_pkg::OP_LOAD: new_cmd.kind = tmv_pkg::CMD_LOAD;
         tmv_pkg::OP_MAC:  new_cmd.kind = tmv_pkg::CMD_MAC;
         tmv_pkg::OP_READ: new_cmd.kind = tmv_pkg::CMD_READ;
         tmv_pkg::OP_NONE: begin
            new_cmd.kind = tmv_pkg::CMD_LOAD;
            keep         = 1'b0;
         end
      endcase
      if ({1'b0, row_index} >= row_count) new_cmd.kind = tmv_pkg::CMD_RANGE;
   end

   assign full      = (count_ff == 2'd2);
   assign enq       = push && !full && keep;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   // Two-entry command queue toward the back part.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ enq;
      rd_ptr_in = rd_ptr_ff ^ cmd_pop;
      count_in  = count_ff + {1'b0, enq} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) q_ff[wr_ptr_ff] <= new_cmd;
   end

endmodule

/* src/tmv_fpu.sv */
// Single-precision multiply/add unit: four stages (operate, find leading
// one, normalize, round). Depends on tmv_pkg.
module tmv_fpu (
   input  logic                 clock,
   input  logic                 reset,
   input  tmv_pkg::fpu_req_type req,
   output logic                 done,
   output logic [31:0]          result
);

   logic               sx, sy;
   logic [7:0]         ex, ey;
   logic [23:0]        mx, my;
   logic [47:0]        prod;
   logic               x_big;
   logic               s_big, s_sml;
   logic [7:0]         e_big, e_sml, d;
   logic [47:0]        mag_big, mag_sml, aligned, sum;
   logic               sticky;
   logic               spec_in;
   logic [31:0]        spec_bits_in;
   logic               sign_in;
   logic [47:0]        mag_in;
   logic signed [11:0] ebase_in;

   logic               s1_valid_ff, s1_spec_ff, s1_sign_ff;
   logic [31:0]        s1_bits_ff;
   logic [47:0]        s1_mag_ff;
   logic signed [11:0] s1_e_ff;
   logic               s2_valid_ff, s2_spec_ff, s2_sign_ff, s2_zero_ff;
   logic [31:0]        s2_bits_ff;
   logic [47:0]        s2_mag_ff;
   logic signed [11:0] s2_e_ff;
   logic [5:0]         s2_k_ff;
   logic               s3_valid_ff, s3_spec_ff, s3_sign_ff, s3_zero_ff;
   logic [31:0]        s3_bits_ff;
   logic [47:0]        s3_x_ff;
   logic signed [11:0] s3_e_ff;
   logic               done_ff;
   logic [31:0]        result_ff;

   // Operate stage: unpack, then multiply or align and add.
   always_comb begin
      sx   = req.x[31];
      sy   = req.y[31];
      ex   = (req.x[30:23] == 8'd0) ? 8'd1 : req.x[30:23];
      ey   = (req.y[30:23] == 8'd0) ? 8'd1 : req.y[30:23];
      mx   = {req.x[30:23] != 8'd0, req.x[22:0]};
      my   = {req.y[30:23] != 8'd0, req.y[22:0]};
      prod = mx * my;

      x_big   = req.x[30:0] >= req.y[30:0];
      s_big   = x_big ? sx : sy;
      s_sml   = x_big ? sy : sx;
      e_big   = x_big ? ex : ey;
      e_sml   = x_big ? ey : ex;
      mag_big = {1'b0, (x_big ? mx : my), 23'd0};
      mag_sml = {1'b0, (x_big ? my : mx), 23'd0};
      d       = e_big - e_sml;
      if (d >= 8'd48) begin
         aligned = 48'd0;
         sticky  = |mag_sml;
      end else begin
         aligned = mag_sml >> d;
         sticky  = |(mag_sml & ((48'd1 << d) - 48'd1));
      end
      aligned = aligned | {47'd0, sticky};
      sum     = (s_big == s_sml) ? (mag_big + aligned) : (mag_big - aligned);

      spec_in      = 1'b1;
      spec_bits_in = 32'd0;
      if (req.op == tmv_pkg::FPU_MUL) begin
         sign_in  = sx ^ sy;
         mag_in   = prod;
         ebase_in = $signed({4'd0, ex}) + $signed({4'd0, ey}) - 12'sd173;
         if (tmv_pkg::is_nan(req.x)) begin
            spec_bits_in = req.x | 32'h0040_0000;
         end else if (tmv_pkg::is_nan(req.y)) begin
            spec_bits_in = req.y | 32'h0040_0000;
         end else if ((tmv_pkg::is_inf(req.x) && tmv_pkg::is_zero(req.y)) ||
                      (tmv_pkg::is_zero(req.x) && tmv_pkg::is_inf(req.y))) begin
            spec_bits_in = tmv_pkg::DefaultNan;
         end else if (tmv_pkg::is_inf(req.x) || tmv_pkg::is_inf(req.y)) begin
            spec_bits_in = {sx ^ sy, 8'hFF, 23'd0};
         end else if (tmv_pkg::is_zero(req.x) || tmv_pkg::is_zero(req.y)) begin
            spec_bits_in = {sx ^ sy, 31'd0};
         end else begin
            spec_in = 1'b0;
         end
      end else begin
         // Exact cancellation gives +0 under round to nearest.
         sign_in  = (sum == 48'd0) ? 1'b0 : s_big;
         mag_in   = sum;
         ebase_in = $signed({4'd0, e_big}) - 12'sd46;
         if (tmv_pkg::is_nan(req.x)) begin
            spec_bits_in = req.x | 32'h0040_0000;
         end else if (tmv_pkg::is_nan(req.y)) begin
            spec_bits_in = req.y | 32'h0040_0000;
         end else if (tmv_pkg::is_inf(req.x) && tmv_pkg::is_inf(req.y) && (sx != sy)) begin
            spec_bits_in = tmv_pkg::DefaultNan;
         end else if (tmv_pkg::is_inf(req.x)) begin
            spec_bits_in = req.x;
         end else if (tmv_pkg::is_inf(req.y)) begin
            spec_bits_in = req.y;
         end else if (tmv_pkg::is_zero(req.x) && tmv_pkg::is_zero(req.y)) begin
            spec_bits_in = {sx & sy, 31'd0};
         end else begin
            spec_in = 1'b0;
         end
      end
   end

   // Valid bits of the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= req.start;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         done_ff     <= s3_valid_ff;
      end
   end

   // Stage data: operate, leading one, normalize, round.
   always_ff @(posedge clock) begin
      s1_spec_ff <= spec_in;
      s1_bits_ff <= spec_bits_in;
      s1_sign_ff <= sign_in;
      s1_mag_ff  <= mag_in;
      s1_e_ff    <= ebase_in;

      s2_spec_ff <= s1_spec_ff;
      s2_bits_ff <= s1_bits_ff;
      s2_sign_ff <= s1_sign_ff;
      s2_zero_ff <= (s1_mag_ff == 48'd0);
      s2_mag_ff  <= s1_mag_ff;
      s2_e_ff    <= s1_e_ff;
      s2_k_ff    <= tmv_pkg::msb48(s1_mag_ff);

      s3_spec_ff <= s2_spec_ff;
      s3_bits_ff <= s2_bits_ff;
      s3_sign_ff <= s2_sign_ff;
      s3_zero_ff <= s2_zero_ff;
      s3_x_ff    <= s2_mag_ff << (6'd47 - s2_k_ff);
      s3_e_ff    <= s2_e_ff + $signed({6'd0, s2_k_ff});

      result_ff  <= s3_spec_ff ? s3_bits_ff :
                    tmv_pkg::round_pack(s3_sign_ff, s3_x_ff, s3_e_ff, s3_zero_ff);
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

/* src/tmv_back.sv */
// Back part: row stores, command sequencer and result queue.
// Depends on tmv_pkg and tmv_fpu.
module tmv_back (
   input  logic             clock,
   input  logic             reset,
   input  tmv_pkg::cfg_type cfg,
   input  logic             cmd_valid,
   input  tmv_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             empty,
   input  logic             pop,
   output tmv_pkg::rsp_type rsp
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_FETCH    = 3'd1;
   localparam logic [2:0] ST_WAIT_P   = 3'd2;
   localparam logic [2:0] ST_WAIT_SUM = 3'd3;
   localparam logic [2:0] ST_WAIT_B   = 3'd4;
   localparam logic [2:0] ST_WAIT_S   = 3'd5;
   localparam logic [2:0] ST_WAIT_R   = 3'd6;
   localparam logic [2:0] ST_PUSH     = 3'd7;

   logic [31:0] seed_mem [tmv_pkg::MaxRows];
   logic [31:0] acc_mem  [tmv_pkg::MaxRows];
   logic [15:0] term_mem [tmv_pkg::MaxRows];

   logic [2:0]           state_ff, state_in;
   tmv_pkg::cmd_type     cur_ff, cur_in;
   logic [31:0]          base_ff, base_in;
   logic [31:0]          value_ff, value_in;
   logic [31:0]          seed_rd_ff, acc_rd_ff;
   logic [15:0]          term_rd_ff;
   logic                 rd_en;
   logic                 wr_en;
   logic [tmv_pkg::RowW-1:0] wr_row;
   logic [31:0]          wr_seed, wr_acc;
   logic [15:0]          wr_term;
   logic                 wr_seed_en;
   tmv_pkg::fpu_req_type fpu_req;
   logic                 fpu_done;
   logic [31:0]          fpu_result;
   logic                 beta_zero;

   tmv_pkg::rsp_type     rq_ff [2];
   logic                 rq_wr_ff, rq_rd_ff;
   logic [1:0]           rq_count_ff, rq_count_in;
   logic                 rq_room;
   logic                 rq_push;
   tmv_pkg::rsp_type     rq_data;
   logic                 rq_pop;

   tmv_fpu u_fpu (
      .clock  (clock),
      .reset  (reset),
      .req    (fpu_req),
      .done   (fpu_done),
      .result (fpu_result)
   );

   assign beta_zero = (cfg.beta_bits[30:0] == 31'd0);
   assign rq_room   = (rq_count_ff != 2'd2);

   // Sequencer: one command at a time through the stores and the unit.
   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      base_in    = base_ff;
      value_in   = value_ff;
      cmd_pop    = 1'b0;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      wr_seed_en = 1'b0;
      wr_row     = cur_ff.row;
      wr_seed    = cmd.c_value;
      wr_acc     = fpu_result;
      wr_term    = (term_rd_ff == 16'hFFFF) ? term_rd_ff : (term_rd_ff + 16'd1);
      rq_push    = 1'b0;
      rq_data.out_row   = cur_ff.row;
      rq_data.out_value = value_ff;
      rq_data.status    = (term_rd_ff == cfg.col_count) ? tmv_pkg::STATUS_OK :
                                                          tmv_pkg::STATUS_COUNT;
      fpu_req.start = 1'b0;
      fpu_req.op    = tmv_pkg::FPU_MUL;
      fpu_req.x     = cur_ff.a_value;
      fpu_req.y     = cur_ff.b_value;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.kind)
                  tmv_pkg::CMD_RANGE: begin
                     if (rq_room) begin
                        cmd_pop           = 1'b1;
                        rq_push           = 1'b1;
                        rq_data.out_row   = cmd.row;
                        rq_data.out_value = 32'd0;
                        rq_data.status    = tmv_pkg::STATUS_RANGE;
                     end
                  end
                  tmv_pkg::CMD_LOAD: begin
                     cmd_pop    = 1'b1;
                     wr_en      = 1'b1;
                     wr_seed_en = 1'b1;
                     wr_row     = cmd.row;
                     wr_acc     = 32'd0;
                     wr_term    = 16'd0;
                  end
                  tmv_pkg::CMD_MAC, tmv_pkg::CMD_READ: begin
                     cmd_pop  = 1'b1;
                     rd_en    = 1'b1;
                     cur_in   = cmd;
                     state_in = ST_FETCH;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            fpu_req.start = 1'b1;
            if (cur_ff.kind == tmv_pkg::CMD_MAC) begin
               state_in = ST_WAIT_P;
            end else if (beta_zero) begin
               base_in   = 32'd0;
               fpu_req.x = cfg.alpha_bits;
               fpu_req.y = acc_rd_ff;
               state_in  = ST_WAIT_S;
            end else begin
               fpu_req.x = cfg.beta_bits;
               fpu_req.y = seed_rd_ff;
               state_in  = ST_WAIT_B;
            end
         end
         ST_WAIT_P: begin
            if (fpu_done) begin
               fpu_req.start = 1'b1;
               fpu_req.op    = tmv_pkg::FPU_ADD;
               fpu_req.x     = acc_rd_ff;
               fpu_req.y     = fpu_result;
               state_in      = ST_WAIT_SUM;
            end
         end
         ST_WAIT_SUM: begin
            if (fpu_done) begin
               wr_en    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_WAIT_B: begin
            if (fpu_done) begin
               base_in       = fpu_result;
               fpu_req.start = 1'b1;
               fpu_req.x     = cfg.alpha_bits;
               fpu_req.y     = acc_rd_ff;
               state_in      = ST_WAIT_S;
            end
         end
         ST_WAIT_S: begin
            if (fpu_done) begin
               fpu_req.start = 1'b1;
               fpu_req.op    = tmv_pkg::FPU_ADD;
               fpu_req.x     = base_ff;
               fpu_req.y     = fpu_result;
               state_in      = ST_WAIT_R;
            end
         end
         ST_WAIT_R: begin
            if (fpu_done) begin
               value_in = fpu_result;
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (rq_room) begin
               rq_push  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      base_ff  <= base_in;
      value_ff <= value_in;
   end

   // Row stores with registered reads.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         seed_rd_ff <= seed_mem[cmd.row];
         acc_rd_ff  <= acc_mem[cmd.row];
         term_rd_ff <= term_mem[cmd.row];
      end
      if (wr_en) begin
         acc_mem[wr_row]  <= wr_acc;
         term_mem[wr_row] <= wr_term;
      end
      if (wr_seed_en) seed_mem[wr_row] <= wr_seed;
   end

   // Two-entry result queue; a stalled receiver blocks the back part only when the queue is full.
   assign rq_pop = pop && !empty;
   assign empty  = (rq_count_ff == 2'd0);
   assign rsp    = rq_ff[rq_rd_ff];

   always_comb begin
      rq_count_in = rq_count_ff + {1'b0, rq_push} - {1'b0, rq_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff    <= 1'b0;
         rq_rd_ff    <= 1'b0;
         rq_count_ff <= 2'd0;
      end else begin
         rq_wr_ff    <= rq_wr_ff ^ rq_push;
         rq_rd_ff    <= rq_rd_ff ^ rq_pop;
         rq_count_ff <= rq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rq_push) rq_ff[rq_wr_ff] <= rq_data;
   end

endmodule

/* src/transposed_matrix_vector_mac.sv */
// Top level of the transposed matrix-vector multiply-accumulate block:
// configuration registers, front and back parts. Depends on tmv_pkg,
// tmv_front and tmv_back.
//
// Usage:
//   Input words enter through push/full: a load seeds a row with its old output
//   value and clears its sum and term count, a multiply-accumulate adds a*b to a
//   row, a read returns beta*seed + alpha*sum for a row. Results leave through
//   empty/pop as a queue; one result word per read, one per item on a row out of
//   range, none for loads and accumulates. Configuration is written through
//   csr_we/csr_index/csr_wdata only while idle: a user rule, not enforced.
// Sequencing:
//   Items are carried out one at a time. A load or a range error is done
//   from the idle state; an accumulate is a store read, then a multiply and
//   an add through the four-stage floating-point unit, and a read is up to
//   three passes through that unit plus the queue write. A read's word is
//   registered after its last unit pass and queued once the queue has room.
// Reset:
//   Synchronous reset empties both queues and loads the register defaults;
//   row stores keep their contents and must be loaded before use.
// Stalls:
//   A two-entry queue parts each side; when the result queue is full the
//   back part waits and the input side fills and raises full.
module transposed_matrix_vector_mac (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic [1:0]               req_opcode,
   input  logic [tmv_pkg::RowW-1:0] req_row_index,
   input  logic [31:0]              req_a_value,
   input  logic [31:0]              req_b_value,
   input  logic [31:0]              req_c_value,
   output logic                     empty,
   input  logic                     pop,
   output logic [tmv_pkg::RowW-1:0] rsp_out_row,
   output logic [31:0]              rsp_out_value,
   output logic [1:0]               rsp_status,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [31:0]              csr_wdata
);

   tmv_pkg::cfg_type cfg_ff, cfg_in;
   logic             cmd_valid;
   tmv_pkg::cmd_type cmd;
   logic             cmd_pop;
   tmv_pkg::rsp_type rsp;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            tmv_pkg::CSR_ALPHA: cfg_in.alpha_bits = csr_wdata;
            tmv_pkg::CSR_BETA:  cfg_in.beta_bits  = csr_wdata;
            tmv_pkg::CSR_ROWS:  cfg_in.row_count  = csr_wdata[10:0];
            tmv_pkg::CSR_COLS:  cfg_in.col_count  = csr_wdata[15:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha_bits <= 32'h3F80_0000;
         cfg_ff.beta_bits  <= 32'd0;
         cfg_ff.row_count  <= 11'd1024;
         cfg_ff.col_count  <= 16'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tmv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .opcode    (req_opcode),
      .row_index (req_row_index),
      .a_value   (req_a_value),
      .b_value   (req_b_value),
      .c_value   (req_c_value),
      .row_count (cfg_ff.row_count),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   tmv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp       (rsp)
   );

   assign rsp_out_row   = rsp.out_row;
   assign rsp_out_value = rsp.out_value;
   assign rsp_status    = rsp.status;

`ifndef SYNTHESIS
   // Both queues come out of reset empty.
   a_reset_empty: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not empty after reset");

   // A waiting word never carries an unused status code.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_status == tmv_pkg::STATUS_OK) ||
                 (rsp_status == tmv_pkg::STATUS_RANGE) ||
                 (rsp_status == tmv_pkg::STATUS_COUNT))
      else $error("result word with unused status");

   // A range error always reports a zero value.
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      !empty && (rsp_status == tmv_pkg::STATUS_RANGE) |-> rsp_out_value == 32'd0)
      else $error("range error with nonzero value");

   // A stalled result word holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_out_value) && $stable(rsp_out_row))
      else $error("result word changed while stalled");
`endif

endmodule

/* bench/tb.sv */
// Self-checking testbench for transposed_matrix_vector_mac: drives load,
// multiply-accumulate and read words and checks every result word.
// Depends on tmv_pkg and the transposed_matrix_vector_mac RTL.
`timescale 1ns / 100ps

module tb;

   typedef struct {
      logic [tmv_pkg::RowW-1:0] row;
      logic [31:0]              value;
      logic [1:0]               status;
   } result_word_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     push = 1'b0;
   logic                     full;
   logic [1:0]               req_opcode = tmv_pkg::OP_NONE;
   logic [tmv_pkg::RowW-1:0] req_row_index = '0;
   logic [31:0]              req_a_value = '0;
   logic [31:0]              req_b_value = '0;
   logic [31:0]              req_c_value = '0;
   logic                     empty;
   logic                     pop = 1'b0;
   logic [tmv_pkg::RowW-1:0] rsp_out_row;
   logic [31:0]              rsp_out_value;
   logic [1:0]               rsp_status;
   logic                     csr_we = 1'b0;
   logic [1:0]               csr_index = tmv_pkg::CSR_ALPHA;
   logic [31:0]              csr_wdata = '0;

   // Shadow copy of the configuration and the row stores.
   logic [31:0] alpha_reg, beta_reg;
   logic [10:0] rows_reg;
   logic [15:0] cols_reg;
   logic [31:0] seed_mem [tmv_pkg::MaxRows];
   logic [31:0] sum_mem [tmv_pkg::MaxRows];
   logic [15:0] terms_mem [tmv_pkg::MaxRows];
   bit          loaded [tmv_pkg::MaxRows];

   result_word_type pending_results[$];
   int              mismatches = 0;
   int              words_sent = 0;
   int              results_seen = 0;
   int              idle_cycles = 0;
   bit              calm = 1'b0;

   transposed_matrix_vector_mac uut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // Single-precision value widened to double; the widening is exact.
   function automatic real sp_to_real(input logic [31:0] b);
      real r;
      if (b[30:23] == 8'hFF) begin
         if (b[22:0] != 0) return $bitstoreal(64'h7FF8_0000_0000_0000);
         return $bitstoreal({b[31], 11'h7FF, 52'd0});
      end
      if (b[30:0] == 0) return $bitstoreal({b[31], 63'd0});
      if (b[30:23] == 0) begin
         r = b[22:0] * (2.0 ** (-149));
         return b[31] ? -r : r;
      end
      return $bitstoreal({b[31], 11'(b[30:23] + 896), b[22:0], 29'd0});
   endfunction

   // Double rounded to single, nearest even, with subnormals and overflow.
   // Rounding an exact-enough double result once more gives the correctly
   // rounded single result, since double carries more than twice the bits.
   function automatic logic [31:0] real_to_sp(input real v);
      logic [63:0]     d;
      logic [52:0]     m;
      int              eb, sh;
      logic [63:0]     kept, rest, half, packed_val;
      d = $realtobits(v);
      if (d[62:52] == 11'h7FF)
         return (d[51:0] != 0) ? 32'h7FC0_0000 : {d[63], 8'hFF, 23'd0};
      if (d[62:0] == 0) return {d[63], 31'd0};
      m  = {1'b1, d[51:0]};
      eb = int'(d[62:52]) - 1023 + 127;
      sh = (eb >= 1) ? 29 : 29 + (1 - eb);
      if (sh > 60) return {d[63], 31'd0};
      kept = 64'(m) >> sh;
      rest = 64'(m) & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rest > half || (rest == half && kept[0])) kept = kept + 1;
      packed_val = (eb >= 1) ? ((64'(eb - 1) << 23) + kept) : kept;
      if (eb >= 255 || packed_val >= 64'h7F80_0000) return {d[63], 8'hFF, 23'd0};
      return {d[63], packed_val[30:0]};
   endfunction

   function automatic bit sp_is_zero(input logic [31:0] b);
      return b[30:0] == 0;
   endfunction

   // Work out the result of one accepted word and update the shadow stores.
   task automatic predict_row_update(input logic [1:0] op,
                                     input logic [tmv_pkg::RowW-1:0] row,
                                     input logic [31:0] a, input logic [31:0] b,
                                     input logic [31:0] c);
      result_word_type w;
      logic [31:0] product, base_part, scaled;
      w.row = row;
      if (op == tmv_pkg::OP_NONE) return;
      if (32'(row) >= 32'(rows_reg)) begin
         w.value  = '0;
         w.status = tmv_pkg::STATUS_RANGE;
         pending_results.push_back(w);
         return;
      end
      case (op)
         tmv_pkg::OP_LOAD: begin
            seed_mem[row]  = c;
            sum_mem[row]   = '0;
            terms_mem[row] = '0;
            loaded[row]    = 1'b1;
         end
         tmv_pkg::OP_MAC: begin
            product      = real_to_sp(sp_to_real(a) * sp_to_real(b));
            sum_mem[row] = real_to_sp(sp_to_real(sum_mem[row]) + sp_to_real(product));
            if (terms_mem[row] != 16'hFFFF) terms_mem[row] = terms_mem[row] + 1;
         end
         default: begin
            base_part = '0;
            if (!sp_is_zero(beta_reg))
               base_part = real_to_sp(sp_to_real(beta_reg) * sp_to_real(seed_mem[row]));
            scaled  = real_to_sp(sp_to_real(alpha_reg) * sp_to_real(sum_mem[row]));
            w.value = real_to_sp(sp_to_real(base_part) + sp_to_real(scaled));
            w.status = (terms_mem[row] == cols_reg) ? tmv_pkg::STATUS_OK
                                                    : tmv_pkg::STATUS_COUNT;
            pending_results.push_back(w);
         end
      endcase
   endtask

   // Send one word; it is predicted at the edge that accepts it.
   task automatic send_word(input logic [1:0] op, input logic [tmv_pkg::RowW-1:0] row,
                            input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] c);
      if (!calm && $urandom_range(0, 99) < 24) begin
         push = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      push          = 1'b1;
      req_opcode    = op;
      req_row_index = row;
      req_a_value   = a;
      req_b_value   = b;
      req_c_value   = c;
      forever begin
         @(posedge clock);
         if (!full) break;
         @(negedge clock);
      end
      predict_row_update(op, row, a, b, c);
      words_sent++;
      @(negedge clock);
      push = 1'b0;
   endtask

   // Wait for every expected result, then let queued accumulates finish.
   task automatic drain_results();
      push = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         tmv_pkg::CSR_ALPHA: alpha_reg = data;
         tmv_pkg::CSR_BETA:  beta_reg  = data;
         tmv_pkg::CSR_ROWS:  rows_reg  = data[10:0];
         default:            cols_reg  = data[15:0];
      endcase
   endtask

   task automatic set_config(input logic [31:0] alpha, input logic [31:0] beta,
                             input logic [10:0] rows, input logic [15:0] cols);
      drain_results();
      write_csr(tmv_pkg::CSR_ALPHA, alpha);
      write_csr(tmv_pkg::CSR_BETA, beta);
      write_csr(tmv_pkg::CSR_ROWS, 32'(rows));
      write_csr(tmv_pkg::CSR_COLS, 32'(cols));
   endtask

   // Mostly moderate magnitudes so sums stay finite, with specials mixed in.
   function automatic logic [31:0] random_float();
      logic [31:0] specials [8] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                    32'hFF80_0000, 32'h7FC0_0000, 32'h0000_0001,
                                    32'h807F_FFFF, 32'h7F7F_FFFF};
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return specials[$urandom_range(0, 7)];
         default: return {1'($urandom), 8'($urandom_range(112, 140)), 23'($urandom)};
      endcase
   endfunction

   // Send a random word to a row; in-range rows never loaded are only ever loaded first.
   task automatic send_random_word(input logic [1:0] op,
                                   input logic [tmv_pkg::RowW-1:0] row);
      if (32'(row) < 32'(rows_reg) && !loaded[row] && op != tmv_pkg::OP_NONE)
         op = tmv_pkg::OP_LOAD;
      send_word(op, row, random_float(), random_float(), random_float());
   endtask

   // Load a row, add a number of products and read it back.
   task automatic send_row_sequence(input logic [tmv_pkg::RowW-1:0] row, input int terms);
      send_word(tmv_pkg::OP_LOAD, row, $urandom, $urandom, random_float());
      repeat (terms)
         send_word(tmv_pkg::OP_MAC, row, random_float(), random_float(), $urandom);
      send_word(tmv_pkg::OP_READ, row, $urandom, $urandom, $urandom);
   endtask

   task automatic test_directed_extremes();
      set_config(32'h3F80_0000, 32'h0000_0000, 11'd1024, 16'd1);
      send_word(tmv_pkg::OP_LOAD, 10'd1023, '0, '0, 32'h4000_0000);
      send_word(tmv_pkg::OP_MAC, 10'd1023, 32'h7F7F_FFFF, 32'h7F7F_FFFF, '0);
      send_word(tmv_pkg::OP_READ, 10'd1023, '0, '0, '0);
      send_word(tmv_pkg::OP_LOAD, 10'd0, '1, '1, 32'hFFFF_FFFF);
      send_word(tmv_pkg::OP_MAC, 10'd0, 32'h7F80_0000, 32'h0000_0000, '0);
      send_word(tmv_pkg::OP_READ, 10'd0, '0, '0, '0);
      send_word(tmv_pkg::OP_LOAD, 10'd1, '0, '0, 32'h3F80_0000);
      send_word(tmv_pkg::OP_MAC, 10'd1, 32'h0000_0001, 32'h3F00_0000, '0);
      send_word(tmv_pkg::OP_MAC, 10'd1, 32'h8080_0000, 32'h3F80_0000, '0);
      send_word(tmv_pkg::OP_READ, 10'd1, '0, '0, '0);
      // A read before the expected number of products reports a short row.
      send_word(tmv_pkg::OP_LOAD, 10'd2, '0, '0, 32'h4040_0000);
      send_word(tmv_pkg::OP_READ, 10'd2, '0, '0, '0);
      // The unused opcode is dropped without a result.
      send_word(tmv_pkg::OP_NONE, 10'd3, '1, '1, '1);
      set_config(32'hBF80_0000, 32'h8000_0000, 11'd1, 16'd2);
      send_word(tmv_pkg::OP_LOAD, 10'd0, '0, '0, 32'h4120_0000);
      send_word(tmv_pkg::OP_MAC, 10'd0, 32'h4000_0000, 32'h4040_0000, '0);
      send_word(tmv_pkg::OP_MAC, 10'd0, 32'hC000_0000, 32'h3F80_0000, '0);
      send_word(tmv_pkg::OP_READ, 10'd0, '0, '0, '0);
      // Every opcode on a row past the row count is refused.
      send_word(tmv_pkg::OP_LOAD, 10'd1, '0, '0, '0);
      send_word(tmv_pkg::OP_MAC, 10'd5, '0, '0, '0);
      send_word(tmv_pkg::OP_READ, 10'd1023, '0, '0, '0);
      send_word(tmv_pkg::OP_NONE, 10'd1023, '0, '0, '0);
      set_config(32'h0000_0000, 32'h4000_0000, 11'd1, 16'd0);
      send_word(tmv_pkg::OP_READ, 10'd0, '0, '0, '0);
      set_config(32'h7F80_0000, 32'h7FC0_0000, 11'd1, 16'd2);
      send_word(tmv_pkg::OP_READ, 10'd0, '0, '0, '0);
   endtask

   // A long row read with its full term count and a second row one product short.
   task automatic test_long_row();
      set_config(32'h3F80_0000, 32'h3FC0_0000, 11'd1024, 16'd40);
      calm = 1'b1;
      send_row_sequence(10'd7, 40);
      send_row_sequence(10'd8, 39);
      calm = 1'b0;
   endtask

   // Well-formed row sequences with random contents, plus stray words.
   task automatic run_random_phase(input int words, input logic [10:0] rows,
                                   input logic [15:0] cols);
      int start;
      int terms;
      set_config(random_float(), ($urandom_range(0, 2) == 0) ? 32'h0 : random_float(),
                 rows, cols);
      start = words_sent;
      while (words_sent - start < words) begin
         if ($urandom_range(0, 99) < 70) begin
            terms = 32'(cols);
            if ($urandom_range(0, 5) == 0) terms = $urandom_range(0, 32'(cols) + 1);
            send_row_sequence(10'($urandom_range(0, 32'(rows) - 1)), terms);
         end else begin
            send_random_word(2'($urandom_range(0, 3)),
                             ($urandom_range(0, 3) == 0) ? 10'($urandom)
                             : 10'($urandom_range(0, 32'(rows) - 1)));
         end
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(200, 11'd4, 16'd3);
      run_random_phase(200, 11'd1024, 16'd1);
      calm = 1'b1;
      run_random_phase(150, 11'd16, 16'd2);
      calm = 1'b0;
      run_random_phase(250, 11'd2, 16'd4);
      run_random_phase(200, 11'd300, 16'd2);
   endtask

   // Results stall at random, apart from the calm stretches.
   always @(negedge clock) pop <= calm || ($urandom_range(0, 99) >= 24);

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      result_word_type w;
      bit bad;
      if (!reset && pop && !empty) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: row %0d value %h status %0d",
                        rsp_out_row, rsp_out_value, rsp_status);
         end else begin
            w = pending_results.pop_front();
            bad = (rsp_out_row !== w.row) || (rsp_status !== w.status);
            if (tmv_pkg::is_nan(w.value)) bad = bad || !tmv_pkg::is_nan(rsp_out_value);
            else bad = bad || (rsp_out_value !== w.value);
            if (bad) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result mismatch: expected row %0d value %h status %0d, ",
                            "got row %0d value %h status %0d"},
                           w.row, w.value, w.status, rsp_out_row, rsp_out_value,
                           rsp_status);
            end
         end
      end
   end

   // Stop a hung run: too long without any word moving on either side.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("transposed_matrix_vector_mac regression: fail");
         $finish;
      end
   end

   initial begin
      alpha_reg = 32'h3F80_0000;
      beta_reg  = 32'h0;
      rows_reg  = 11'd1024;
      cols_reg  = 16'd1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_extremes();
      test_random_traffic();
      test_long_row();
      drain_results();
      $display("Sent %0d words and checked %0d results over directed, random and",
               words_sent, results_seen);
      $display("long-row phases; %0d mismatches.", mismatches);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("transposed_matrix_vector_mac regression: pass");
      else
         $display("transposed_matrix_vector_mac regression: fail");
      $finish;
   end
endmodule

/* sim.f */
src/tmv_pkg.sv
src/tmv_front.sv
src/tmv_fpu.sv
src/tmv_back.sv
src/transposed_matrix_vector_mac.sv
bench/tb.sv
